>>> rtl/rv32i_imm_jump_execute_core_macros.svh
// assertion macros for the rv32i immediate and jump execute core
// included by the files that carry concurrent assertions; no other dependencies
`ifndef RV32I_IMM_JUMP_EXECUTE_CORE_MACROS_SVH
`define RV32I_IMM_JUMP_EXECUTE_CORE_MACROS_SVH

`ifndef NO_ASSERTIONS

// property checked on every edge outside reset
`define RIJE_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// signal held low at every edge while reset is applied
`define RIJE_ASSERT_RST(lbl, clk, rst_n, sig, msg) \
	lbl: assert property (@(posedge clk) !rst_n |-> !(sig)) else $error(msg);

`else

`define RIJE_ASSERT(lbl, clk, rst_n, prop, msg)
`define RIJE_ASSERT_RST(lbl, clk, rst_n, sig, msg)

`endif

`endif

>>> rtl/rije_pkg.sv
// shared types and constants for the rv32i immediate and jump execute core
// no dependencies
package rije_pkg;

	localparam int XLEN = 32;
	localparam int REG_IDX_W = 5;

	// major opcodes, instr[6:2]
	localparam logic [4:0] OPC_OP_IMM = 5'd4;
	localparam logic [4:0] OPC_AUIPC  = 5'd5;
	localparam logic [4:0] OPC_LUI    = 5'd13;
	localparam logic [4:0] OPC_JALR   = 5'd25;
	localparam logic [4:0] OPC_JAL    = 5'd27;

	localparam logic [1:0] OPC_LOW_32BIT = 2'b11;

	// op-imm funct3 codes
	localparam logic [2:0] F3_ADDI  = 3'd0;
	localparam logic [2:0] F3_SLLI  = 3'd1;
	localparam logic [2:0] F3_SLTI  = 3'd2;
	localparam logic [2:0] F3_SLTIU = 3'd3;
	localparam logic [2:0] F3_XORI  = 3'd4;
	localparam logic [2:0] F3_SRXI  = 3'd5;
	localparam logic [2:0] F3_ORI   = 3'd6;
	localparam logic [2:0] F3_ANDI  = 3'd7;
	localparam logic [2:0] F3_JALR  = 3'd0;

	localparam logic [XLEN-1:0] INSTR_BYTES = 32'd4;

	typedef struct packed {
		logic [REG_IDX_W-1:0] rd_index;
		logic [XLEN-1:0]      rd_value;
		logic                 rd_write;
		logic [XLEN-1:0]      next_pc;
		logic                 illegal;
	} result_t;

endpackage

>>> rtl/rije_in_if.sv
// issue channel: instruction word, rs1 value and pc with valid/ready
// depends on rije_pkg for widths
interface rije_in_if;
	logic                       valid;
	logic                       ready;
	logic [rije_pkg::XLEN-1:0]  instr;
	logic [rije_pkg::XLEN-1:0]  rs1_value;
	logic [rije_pkg::XLEN-1:0]  pc;

	modport source(output valid, instr, rs1_value, pc, input ready);
	modport sink(input valid, instr, rs1_value, pc, output ready);
endinterface

>>> rtl/rije_out_if.sv
// result channel: destination write, next pc and illegal flag with valid/ready
// depends on rije_pkg for widths
interface rije_out_if;
	logic                           valid;
	logic                           ready;
	logic [rije_pkg::REG_IDX_W-1:0] rd_index;
	logic [rije_pkg::XLEN-1:0]      rd_value;
	logic                           rd_write;
	logic [rije_pkg::XLEN-1:0]      next_pc;
	logic                           illegal;

	modport source(output valid, rd_index, rd_value, rd_write, next_pc, illegal, input ready);
	modport sink(input valid, rd_index, rd_value, rd_write, next_pc, illegal, output ready);
endinterface

>>> rtl/rije_alu.sv
// op-imm arithmetic: add, shifts, compares and logic against the i-immediate
// depends on rije_pkg
module rije_alu (
	input  logic [rije_pkg::XLEN-1:0] instr,
	input  logic [rije_pkg::XLEN-1:0] rs1_value,
	input  logic [rije_pkg::XLEN-1:0] imm_i,
	output logic [rije_pkg::XLEN-1:0] alu_value
);
	import rije_pkg::*;

	logic [2:0] funct3;
	logic [4:0] shamt;

	assign funct3 = instr[14:12];
	assign shamt  = instr[24:20];

	always_comb begin
		unique case (funct3)
			F3_ADDI:  alu_value = rs1_value + imm_i;
			F3_SLLI:  alu_value = rs1_value << shamt;
			F3_SLTI:  alu_value = {{(XLEN-1){1'b0}}, ($signed(rs1_value) < $signed(imm_i))};
			F3_SLTIU: alu_value = {{(XLEN-1){1'b0}}, (rs1_value < imm_i)};
			F3_XORI:  alu_value = rs1_value ^ imm_i;
			F3_SRXI: begin
				// instr[30] picks arithmetic shift
				if (instr[30]) begin
					alu_value = XLEN'($signed(rs1_value) >>> shamt);
				end else begin
					alu_value = rs1_value >> shamt;
				end
			end
			F3_ORI:   alu_value = rs1_value | imm_i;
			F3_ANDI:  alu_value = rs1_value & imm_i;
			default:  alu_value = rs1_value & imm_i;
		endcase
	end
endmodule

>>> rtl/rije_exec.sv
// decode and result select for op-imm, lui, auipc, jalr and jal
// depends on rije_pkg and rije_alu
module rije_exec (
	input  logic [rije_pkg::XLEN-1:0] instr,
	input  logic [rije_pkg::XLEN-1:0] rs1_value,
	input  logic [rije_pkg::XLEN-1:0] pc,
	output rije_pkg::result_t         res
);
	import rije_pkg::*;

	logic [XLEN-1:0] imm_i;
	logic [XLEN-1:0] imm_u;
	logic [XLEN-1:0] imm_j;
	logic [XLEN-1:0] seq_pc;
	logic [XLEN-1:0] jalr_sum;
	logic [XLEN-1:0] alu_value;

	assign imm_i    = {{(XLEN-12){instr[31]}}, instr[31:20]};
	assign imm_u    = {instr[31:12], 12'b0};
	assign imm_j    = {{(XLEN-20){instr[31]}}, instr[19:12], instr[20], instr[30:21], 1'b0};
	assign seq_pc   = pc + INSTR_BYTES;
	assign jalr_sum = rs1_value + imm_i;

	rije_alu u_alu (
		.instr     (instr),
		.rs1_value (rs1_value),
		.imm_i     (imm_i),
		.alu_value (alu_value)
	);

	always_comb begin
		res.rd_index = instr[11:7];
		res.rd_value = '0;
		res.rd_write = 1'b0;
		res.next_pc  = seq_pc;
		res.illegal  = 1'b0;
		if (instr[1:0] != OPC_LOW_32BIT) begin
			res.illegal = 1'b1;
		end else begin
			unique case (instr[6:2])
				OPC_OP_IMM: begin
					res.rd_value = alu_value;
					res.rd_write = 1'b1;
				end
				OPC_AUIPC: begin
					res.rd_value = pc + imm_u;
					res.rd_write = 1'b1;
				end
				OPC_LUI: begin
					res.rd_value = imm_u;
					res.rd_write = 1'b1;
				end
				OPC_JALR: begin
					if (instr[14:12] != F3_JALR) begin
						res.illegal = 1'b1;
					end else begin
						res.rd_value = seq_pc;
						res.rd_write = 1'b1;
						res.next_pc  = {jalr_sum[XLEN-1:1], 1'b0};
					end
				end
				OPC_JAL: begin
					res.rd_value = seq_pc;
					res.rd_write = 1'b1;
					res.next_pc  = pc + imm_j;
				end
				default: begin
					res.illegal = 1'b1;
				end
			endcase
		end
	end
endmodule

>>> rtl/rije_out_stage.sv
// result register driving the result channel
// depends on rije_pkg and rije_out_if
module rije_out_stage (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              load_valid,
	output logic              load_ready,
	input  rije_pkg::result_t res_d,
	rije_out_if.source        result
);
	import rije_pkg::*;

	logic    valid_s2;
	result_t res_s2;

	// register frees up in the same cycle its content is taken
	assign load_ready = !valid_s2 || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_ready) begin
			valid_s2 <= load_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load_valid && load_ready) begin
			res_s2 <= res_d;
		end
	end

	assign result.valid    = valid_s2;
	assign result.rd_index = res_s2.rd_index;
	assign result.rd_value = res_s2.rd_value;
	assign result.rd_write = res_s2.rd_write;
	assign result.next_pc  = res_s2.next_pc;
	assign result.illegal  = res_s2.illegal;
endmodule

>>> rtl/rv32i_imm_jump_execute_core.sv
// rv32i execute core for op-imm, lui, auipc, jalr and jal
// issue transfer to result valid passes the issue register, then the result register; one transfer
// per cycle sustained while results are taken; the issue register feeds decode/alu logic into the result register
// a stalled result still lets one more instruction into the issue register
// asynchronous active-low reset empties both registers; no other state
// depends on rije_pkg, rije_in_if, rije_out_if, rije_exec, rije_out_stage
`include "rv32i_imm_jump_execute_core_macros.svh"

module rv32i_imm_jump_execute_core (
	input  logic      clk,
	input  logic      arst_n,
	rije_in_if.sink   issue,
	rije_out_if.source result
);
	import rije_pkg::*;

	logic            valid_s1;
	logic [XLEN-1:0] instr_s1;
	logic [XLEN-1:0] rs1_s1;
	logic [XLEN-1:0] pc_s1;
	logic            s2_ready;
	result_t         exec_res;

	assign issue.ready = !valid_s1 || s2_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (issue.ready) begin
			valid_s1 <= issue.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (issue.valid && issue.ready) begin
			instr_s1 <= issue.instr;
			rs1_s1   <= issue.rs1_value;
			pc_s1    <= issue.pc;
		end
	end

	rije_exec u_exec (
		.instr     (instr_s1),
		.rs1_value (rs1_s1),
		.pc        (pc_s1),
		.res       (exec_res)
	);

	rije_out_stage u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.load_valid (valid_s1),
		.load_ready (s2_ready),
		.res_d      (exec_res),
		.result     (result)
	);

	`RIJE_ASSERT_RST(a_rst_empty, clk, arst_n, valid_s1 || result.valid, "registers not empty in reset")
	`RIJE_ASSERT(a_issue_free, clk, arst_n, !valid_s1 |-> issue.ready, "empty issue register refuses transfer")
	`RIJE_ASSERT(a_issue_hold, clk, arst_n, valid_s1 && !s2_ready |=> valid_s1 && $stable(instr_s1) && $stable(pc_s1), "stalled instruction lost")
	`RIJE_ASSERT(a_issue_load, clk, arst_n, issue.valid && issue.ready |=> valid_s1, "transfer not captured")
	`RIJE_ASSERT(a_illegal_nowrite, clk, arst_n, result.valid && result.illegal |-> !result.rd_write && result.rd_value == '0, "illegal result writes rd")

endmodule
